/* src/strp_pkg.sv */
// ----------------------------------------------------------------------------
// strp_pkg
// types and constants shared by the string to unsigned parser
// ----------------------------------------------------------------------------
package strp_pkg;

  localparam int unsigned VALUE_BITS   = 64;
  localparam int unsigned BASE_BITS    = 6;
  localparam int unsigned END_POS_BITS = 16;

  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_BITS-1:0] NOT_DIGIT  = 6'd36;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;

  typedef enum logic [5:0] {
    PH_SPACE  = 6'b000001,
    PH_SIGNED = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_AFTERX = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_WAIT   = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NODIG   = 2'd1,
    ST_OVF     = 2'd2,
    ST_BADBASE = 2'd3
  } status_t;

  typedef struct packed {
    phase_t                phase;
    logic [VALUE_BITS-1:0] acc;
    logic                  neg;
    logic                  ovf;
    logic                  dig;
  } parse_state_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]   value;
    status_t                 status;
    logic [END_POS_BITS-1:0] end_pos;
    logic                    minus;
  } result_t;

endpackage

/* src/strp_in_if.sv */
// ----------------------------------------------------------------------------
// strp_in_if
// character channel: one byte of the string per word
// ----------------------------------------------------------------------------
interface strp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

/* src/strp_out_if.sv */
// ----------------------------------------------------------------------------
// strp_out_if
// result channel: one parsed number per word
// ----------------------------------------------------------------------------
interface strp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] parsed_value;
  logic [1:0]  parse_status;
  logic [15:0] end_position;
  logic        minus_seen;

  modport source (output valid, output parsed_value, output parse_status,
                  output end_position, output minus_seen, input ready);
  modport sink (input valid, input parsed_value, input parse_status,
                input end_position, input minus_seen, output ready);
endinterface

/* src/strp_step.sv */
// ----------------------------------------------------------------------------
// strp_step
// one character of parsing: next state, result and emit flag
// ----------------------------------------------------------------------------
module strp_step #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  strp_pkg::parse_state_t             cur,
  input  logic [POSITION_BITS-1:0]           cur_pos,
  input  logic [POSITION_BITS-1:0]           cur_em,
  input  logic [7:0]                         char_code,
  input  logic                               last_char,
  input  logic [strp_pkg::BASE_BITS-1:0]     base_raw,
  output strp_pkg::parse_state_t             nxt,
  output logic [POSITION_BITS-1:0]           nxt_pos,
  output logic [POSITION_BITS-1:0]           nxt_em,
  output logic                               emit,
  output strp_pkg::result_t                  res
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam int unsigned PROD_BITS = strp_pkg::VALUE_BITS + strp_pkg::BASE_BITS + 1;

  logic [strp_pkg::BASE_BITS-1:0] base;
  logic [strp_pkg::BASE_BITS-1:0] d;
  logic                           base_ok;
  logic                           isdig;
  logic                           is_space;
  logic [PROD_BITS-1:0]           prod;
  logic                           fits;
  logic                           take;
  logic                           go_signed;
  logic                           bad;
  strp_pkg::parse_state_t         st;
  logic [POSITION_BITS-1:0]       em;

  function automatic logic [strp_pkg::BASE_BITS-1:0] digit_of(input logic [7:0] c);
    logic [strp_pkg::BASE_BITS-1:0] v;
    v = strp_pkg::NOT_DIGIT;
    if (c >= strp_pkg::CH_ZERO && c <= strp_pkg::CH_NINE) begin
      v = 6'(c - strp_pkg::CH_ZERO);
    end else if (c >= strp_pkg::CH_UP_A && c <= strp_pkg::CH_UP_Z) begin
      v = 6'(c - strp_pkg::CH_UP_A + 8'd10);
    end else if (c >= strp_pkg::CH_LO_A && c <= strp_pkg::CH_LO_Z) begin
      v = 6'(c - strp_pkg::CH_LO_A + 8'd10);
    end
    return v;
  endfunction

  assign base     = (base_raw == '0) ? strp_pkg::BASE_RESET : base_raw;
  assign base_ok  = (base >= strp_pkg::BASE_MIN) && (base <= strp_pkg::BASE_MAX);
  assign d        = digit_of(char_code);
  assign isdig    = d < base;
  assign is_space = (char_code == strp_pkg::CH_SPACE) ||
                    (char_code >= strp_pkg::CH_TAB && char_code <= strp_pkg::CH_CR);
  assign prod     = PROD_BITS'(cur.acc) * PROD_BITS'(base) + PROD_BITS'(d);
  assign fits     = (prod[PROD_BITS-1:strp_pkg::VALUE_BITS] == '0);

  always_comb begin
    st        = cur;
    em        = cur_em;
    emit      = 1'b0;
    bad       = 1'b0;
    take      = 1'b0;
    go_signed = 1'b0;

    if (cur.phase != strp_pkg::PH_WAIT && !base_ok) begin
      emit     = 1'b1;
      bad      = 1'b1;
      st.phase = strp_pkg::PH_WAIT;
    end else begin
      if (cur.phase == strp_pkg::PH_SPACE) begin
        if (is_space) begin
          st.phase = strp_pkg::PH_SPACE;
        end else if (char_code == strp_pkg::CH_PLUS || char_code == strp_pkg::CH_MINUS) begin
          st.neg   = (char_code == strp_pkg::CH_MINUS);
          st.phase = strp_pkg::PH_SIGNED;
        end else begin
          go_signed = 1'b1;
        end
      end
      if (cur.phase == strp_pkg::PH_SIGNED || go_signed) begin
        if (base == strp_pkg::BASE_HEX && char_code == strp_pkg::CH_ZERO) begin
          take     = 1'b1;
          st.phase = strp_pkg::PH_ZERO;
        end else if (isdig) begin
          take     = 1'b1;
          st.phase = strp_pkg::PH_DIGITS;
        end else begin
          emit     = 1'b1;
          st.phase = strp_pkg::PH_WAIT;
        end
      end else if (cur.phase == strp_pkg::PH_ZERO) begin
        if (char_code == strp_pkg::CH_LO_X || char_code == strp_pkg::CH_UP_X) begin
          st.phase = strp_pkg::PH_AFTERX;
        end else if (isdig) begin
          take     = 1'b1;
          st.phase = strp_pkg::PH_DIGITS;
        end else begin
          emit     = 1'b1;
          st.phase = strp_pkg::PH_WAIT;
        end
      end else if (cur.phase == strp_pkg::PH_AFTERX || cur.phase == strp_pkg::PH_DIGITS) begin
        if (isdig) begin
          take     = 1'b1;
          st.phase = strp_pkg::PH_DIGITS;
        end else begin
          emit     = 1'b1;
          st.phase = strp_pkg::PH_WAIT;
        end
      end
    end

    if (take) begin
      if (!cur.ovf) begin
        if (fits) begin
          st.acc = prod[strp_pkg::VALUE_BITS-1:0];
        end else begin
          st.ovf = 1'b1;
        end
      end
      st.dig = 1'b1;
      em     = (cur_pos < POS_MAX) ? cur_pos + 1'b1 : POS_MAX;
    end

    // end of string closes any open parse
    if (last_char && !emit && st.phase != strp_pkg::PH_WAIT) begin
      emit = 1'b1;
    end

    res.value   = '0;
    res.status  = strp_pkg::ST_OK;
    res.end_pos = '0;
    res.minus   = 1'b0;
    if (bad) begin
      res.status = strp_pkg::ST_BADBASE;
    end else if (!st.dig) begin
      res.status = strp_pkg::ST_NODIG;
    end else begin
      res.end_pos = strp_pkg::END_POS_BITS'(em);
      res.minus   = st.neg;
      if (st.ovf) begin
        res.value  = '1;
        res.status = strp_pkg::ST_OVF;
      end else begin
        res.value = st.neg ? (~st.acc + 1'b1) : st.acc;
      end
    end
    if (emit) begin
      st.phase = strp_pkg::PH_WAIT;
    end

    if (last_char) begin
      nxt.phase = strp_pkg::PH_SPACE;
      nxt.acc   = '0;
      nxt.neg   = 1'b0;
      nxt.ovf   = 1'b0;
      nxt.dig   = 1'b0;
      nxt_pos   = '0;
      nxt_em    = '0;
    end else begin
      nxt     = st;
      nxt_em  = em;
      nxt_pos = (cur_pos < POS_MAX) ? cur_pos + 1'b1 : POS_MAX;
    end
  end

endmodule

/* src/string_to_unsigned_parser_core.sv */
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_core
// strtoull style parser: one character word in, one number word per string out
//
//   channel    dir   fields                                              handshake
//   in_word    in    char_code[7:0], last_char                           valid/ready
//   out_word   out   parsed_value[63:0], parse_status[1:0],              valid/ready
//                    end_position[15:0], minus_seen
//   cfg        in    cfg_data[5:0] (number_base)                         cfg_we
//
// one character per cycle sustained while number words are taken; the digit
// multiply-add and the state update work on the word held in the input register,
// so a number word lands in the result register when its character leaves that register
// synchronous reset restores base 10 and the white space phase, no pass needed
// a character that emits a number word waits in the input register while the
// result register is full and not taken; other characters still flow
// ----------------------------------------------------------------------------
module string_to_unsigned_parser_core #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [strp_pkg::BASE_BITS-1:0] cfg_data,
  strp_in_if.sink                       in_word,
  strp_out_if.source                    out_word
);

  logic [strp_pkg::BASE_BITS-1:0] number_base;
  logic                           in_v;
  logic [7:0]                     in_char;
  logic                           in_last;
  strp_pkg::parse_state_t         state;
  strp_pkg::parse_state_t         state_next;
  logic [POSITION_BITS-1:0]       pos;
  logic [POSITION_BITS-1:0]       pos_next;
  logic [POSITION_BITS-1:0]       end_mark;
  logic [POSITION_BITS-1:0]       end_mark_next;
  logic                           emit;
  strp_pkg::result_t              res_next;
  strp_pkg::result_t              res;
  logic                           out_v;
  logic                           fire;

  strp_step #(.POSITION_BITS(POSITION_BITS)) u_step (
    .cur       (state),
    .cur_pos   (pos),
    .cur_em    (end_mark),
    .char_code (in_char),
    .last_char (in_last),
    .base_raw  (number_base),
    .nxt       (state_next),
    .nxt_pos   (pos_next),
    .nxt_em    (end_mark_next),
    .emit      (emit),
    .res       (res_next)
  );

  assign fire          = in_v && (!emit || !out_v || out_word.ready);
  assign in_word.ready = !in_v || fire;

  assign out_word.valid        = out_v;
  assign out_word.parsed_value = res.value;
  assign out_word.parse_status = res.status;
  assign out_word.end_position = res.end_pos;
  assign out_word.minus_seen   = res.minus;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= strp_pkg::BASE_RESET;
    end else if (cfg_we) begin
      number_base <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_word.ready) begin
      in_v <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ready && in_word.valid) begin
      in_char <= in_word.char_code;
      in_last <= in_word.last_char;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= strp_pkg::PH_SPACE;
      state.acc   <= '0;
      state.neg   <= 1'b0;
      state.ovf   <= 1'b0;
      state.dig   <= 1'b0;
      pos         <= '0;
      end_mark    <= '0;
    end else if (fire) begin
      state    <= state_next;
      pos      <= pos_next;
      end_mark <= end_mark_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (fire && emit) begin
      out_v <= 1'b1;
    end else if (out_word.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res <= res_next;
    end
  end

  a_badbase_zero : assert property (@(posedge clk) disable iff (rst)
    out_v && res.status == strp_pkg::ST_BADBASE |->
      res.value == '0 && res.end_pos == '0 && !res.minus)
    else $error("invalid base word carries data");

  a_nodig_zero : assert property (@(posedge clk) disable iff (rst)
    out_v && res.status == strp_pkg::ST_NODIG |->
      res.value == '0 && res.end_pos == '0)
    else $error("no digit word carries data");

  a_ovf_ones : assert property (@(posedge clk) disable iff (rst)
    out_v && res.status == strp_pkg::ST_OVF |-> res.value == '1)
    else $error("overflow word not saturated");

  a_last_clears : assert property (@(posedge clk) disable iff (rst)
    fire && in_last |=> state.phase == strp_pkg::PH_SPACE && pos == '0 && !state.dig)
    else $error("string end did not clear state");

  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    in_v && !fire |=> in_v && $stable(in_char) && $stable(in_last))
    else $error("stalled input word lost");

endmodule

/* dv/string_to_unsigned_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_core_tb
// self-checking bench for the string to unsigned parser: character words go
// in with random gaps while gaps are on, a local model of the parse predicts one
// number word per string, and every number word is checked field by field in order
// ----------------------------------------------------------------------------
module string_to_unsigned_parser_core_tb;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned POS_MAX = (1 << POSITION_BITS) - 1;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [strp_pkg::BASE_BITS-1:0] cfg_data;

  strp_in_if in_word ();
  strp_out_if out_word ();

  string_to_unsigned_parser_core #(
    .POSITION_BITS(POSITION_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_word(in_word),
    .out_word(out_word)
  );

  // parse model state
  logic [strp_pkg::BASE_BITS-1:0]  base_reg;
  strp_pkg::phase_t                m_phase;
  logic [strp_pkg::VALUE_BITS-1:0] m_acc;
  logic                            m_neg;
  logic                            m_ovf;
  logic                            m_dig;
  int unsigned                     m_pos;
  int unsigned                     m_end;

  strp_pkg::result_t pending_numbers[$];

  int  error_count;
  int  chars_sent;
  int  numbers_seen;
  int  strings_sent;
  int  hold_req;
  bit  gaps_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    if (c >= strp_pkg::CH_ZERO && c <= strp_pkg::CH_NINE)
      return 6'(c - strp_pkg::CH_ZERO);
    if (c >= strp_pkg::CH_UP_A && c <= strp_pkg::CH_UP_Z)
      return 6'(c - strp_pkg::CH_UP_A + 8'd10);
    if (c >= strp_pkg::CH_LO_A && c <= strp_pkg::CH_LO_Z)
      return 6'(c - strp_pkg::CH_LO_A + 8'd10);
    return strp_pkg::NOT_DIGIT;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == strp_pkg::CH_SPACE || (c >= strp_pkg::CH_TAB && c <= strp_pkg::CH_CR);
  endfunction

  function void clear_string();
    m_phase = strp_pkg::PH_SPACE;
    m_acc = '0;
    m_neg = 1'b0;
    m_ovf = 1'b0;
    m_dig = 1'b0;
    m_pos = 0;
    m_end = 0;
  endfunction

  function void take_digit(input logic [63:0] d, input logic [63:0] b);
    if (!m_ovf) begin
      if ((64'hFFFF_FFFF_FFFF_FFFF - d) / b < m_acc) m_ovf = 1'b1;
      else m_acc = m_acc * b + d;
    end
    m_dig = 1'b1;
    m_end = (m_pos < POS_MAX) ? m_pos + 1 : POS_MAX;
  endfunction

  function void push_number(input strp_pkg::status_t forced);
    strp_pkg::result_t r;
    r.value = '0;
    r.status = strp_pkg::ST_OK;
    r.end_pos = '0;
    r.minus = 1'b0;
    if (forced == strp_pkg::ST_BADBASE) begin
      r.status = strp_pkg::ST_BADBASE;
    end else if (!m_dig) begin
      r.status = strp_pkg::ST_NODIG;
    end else begin
      r.end_pos = m_end[strp_pkg::END_POS_BITS-1:0];
      r.minus = m_neg;
      if (m_ovf) begin
        r.value = '1;
        r.status = strp_pkg::ST_OVF;
      end else begin
        r.value = m_neg ? 64'd0 - m_acc : m_acc;
      end
    end
    pending_numbers.push_back(r);
    m_phase = strp_pkg::PH_WAIT;
  endfunction

  function void parse_char(input logic [7:0] c, input logic last);
    logic [63:0] b;
    logic [63:0] d;
    bit isdig;
    bit emitted;
    bit as_signed;
    b = (base_reg == '0) ? 64'd10 : 64'(base_reg);
    d = 64'(digit_value(c));
    isdig = d < b;
    emitted = 1'b0;
    as_signed = 1'b0;
    if (m_phase != strp_pkg::PH_WAIT &&
        (b < strp_pkg::BASE_MIN || b > strp_pkg::BASE_MAX)) begin
      push_number(strp_pkg::ST_BADBASE);
      emitted = 1'b1;
    end else begin
      unique case (m_phase)
        strp_pkg::PH_SPACE: begin
          if (!is_blank(c)) begin
            if (c == strp_pkg::CH_PLUS || c == strp_pkg::CH_MINUS) begin
              m_neg = (c == strp_pkg::CH_MINUS);
              m_phase = strp_pkg::PH_SIGNED;
            end else begin
              as_signed = 1'b1;
            end
          end
        end
        strp_pkg::PH_SIGNED: as_signed = 1'b1;
        strp_pkg::PH_ZERO: begin
          if (c == strp_pkg::CH_LO_X || c == strp_pkg::CH_UP_X) begin
            m_phase = strp_pkg::PH_AFTERX;
          end else if (isdig) begin
            take_digit(d, b);
            m_phase = strp_pkg::PH_DIGITS;
          end else begin
            push_number(strp_pkg::ST_OK);
            emitted = 1'b1;
          end
        end
        strp_pkg::PH_AFTERX, strp_pkg::PH_DIGITS: begin
          if (isdig) begin
            take_digit(d, b);
            m_phase = strp_pkg::PH_DIGITS;
          end else begin
            push_number(strp_pkg::ST_OK);
            emitted = 1'b1;
          end
        end
        default: ;
      endcase
      if (as_signed) begin
        if (b == strp_pkg::BASE_HEX && c == strp_pkg::CH_ZERO) begin
          take_digit(64'd0, b);
          m_phase = strp_pkg::PH_ZERO;
        end else if (isdig) begin
          take_digit(d, b);
          m_phase = strp_pkg::PH_DIGITS;
        end else begin
          push_number(strp_pkg::ST_OK);
          emitted = 1'b1;
        end
      end
    end
    if (last) begin
      if (!emitted && m_phase != strp_pkg::PH_WAIT) push_number(strp_pkg::ST_OK);
      clear_string();
    end else if (m_pos < POS_MAX) begin
      m_pos++;
    end
  endfunction

  // called and returns at a falling edge
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_word.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.char_code <= c;
    in_word.last_char <= last;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
    parse_char(c, last);
    chars_sent++;
    if (last) strings_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // quiet the input and let every number word and trailing character drain
  task automatic drain();
    in_word.valid <= 1'b0;
    while (pending_numbers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_base(input logic [strp_pkg::BASE_BITS-1:0] b);
    cfg_data <= b;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    base_reg = b;
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return strp_pkg::CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? strp_pkg::CH_UP_A : strp_pkg::CH_LO_A) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? strp_pkg::CH_SPACE : strp_pkg::CH_TAB + 8'(k);
  endfunction

  task automatic send_random_string();
    logic [7:0] text[$];
    int eff;
    int n;
    bit maxrun;
    eff = (base_reg == '0) ? 10 : int'(base_reg);
    if (eff < 2 || eff > 36) eff = 10;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) text.push_back(blank_char());
      case ($urandom_range(0, 2))
        0: text.push_back(strp_pkg::CH_PLUS);
        1: text.push_back(strp_pkg::CH_MINUS);
        default: ;
      endcase
      if (eff == 16 && $urandom_range(0, 1)) begin
        text.push_back(strp_pkg::CH_ZERO);
        text.push_back($urandom_range(0, 1) ? strp_pkg::CH_LO_X : strp_pkg::CH_UP_X);
      end
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
      maxrun = ($urandom_range(0, 5) == 0);
      repeat (n) text.push_back(digit_char(maxrun ? eff - 1 : $urandom_range(0, eff - 1)));
      if ($urandom_range(0, 1)) text.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0)
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic test_directed();
    send_text(" -7");
    send_text("+x");
    send_text("\r5z");
    drain();
    write_base(strp_pkg::BASE_HEX);
    send_text("0x");
    send_text("0Xg");
    send_text("-fF");
    drain();
    write_base(strp_pkg::BASE_MAX);
    send_text("zZ");
    drain();
    write_base(6'd0);
    send_text("9");
    drain();
    write_base(6'd1);
    send_text("5");
    drain();
    write_base(6'd63);
    send_text("1");
    drain();
    // base change between two characters of one string
    write_base(strp_pkg::BASE_RESET);
    send_char(strp_pkg::CH_ZERO + 8'd1, 1'b0);
    drain();
    write_base(strp_pkg::BASE_HEX);
    send_char(strp_pkg::CH_LO_A + 8'd5, 1'b1);
  endtask

  task automatic test_limits();
    drain();
    write_base(strp_pkg::BASE_HEX);
    send_text("ffffffffffffffff");
    send_text("-10000000000000000");
    drain();
    write_base(strp_pkg::BASE_RESET);
    send_text("18446744073709551615");
    send_text("18446744073709551616");
  endtask

  task automatic test_random_strings();
    logic [strp_pkg::BASE_BITS-1:0] plan[10];
    int target;
    plan = '{6'd10, 6'd2, 6'd16, 6'd36, 6'd0, 6'd8, 6'd1, 6'd37, 6'd63, 6'd16};
    foreach (plan[p]) begin
      drain();
      gaps_on = (p % 3 != 2);
      write_base((p == 9) ? 6'($urandom_range(2, 36)) : plan[p]);
      target = chars_sent + 55;
      while (chars_sent < target) send_random_string();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    int i;
    drain();
    write_base(strp_pkg::BASE_RESET);
    hold_req = 300;
    for (i = 0; i < 40; i++) send_char(strp_pkg::CH_ZERO + 8'(i % 10), 1'b1);
    drain();
  endtask

  task automatic test_long_string();
    int i;
    drain();
    write_base(strp_pkg::BASE_RESET);
    for (i = 0; i < 100; i++) send_char(strp_pkg::CH_ZERO, 1'b0);
    send_char(strp_pkg::CH_ZERO + 8'd5, 1'b1);
    send_text("12");
  endtask

  task automatic test_streaming();
    int target;
    drain();
    gaps_on = 1'b0;
    write_base(strp_pkg::BASE_HEX);
    target = chars_sent + 120;
    while (chars_sent < target) send_random_string();
  endtask

  // result side ready, with random stalls and requested long holds
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_word.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_word.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_word.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_word.ready <= 1'b0;
      end else begin
        out_word.ready <= 1'b1;
      end
    end
  end

  // number word checker
  initial begin
    strp_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_word.valid && out_word.ready) begin
        numbers_seen++;
        if (pending_numbers.size() == 0) begin
          report($sformatf("number word %0d arrived with none expected", numbers_seen));
        end else begin
          want = pending_numbers.pop_front();
          if (out_word.parsed_value !== want.value)
            report($sformatf("word %0d value %h, expected %h", numbers_seen,
                             out_word.parsed_value, want.value));
          if (out_word.parse_status !== want.status)
            report($sformatf("word %0d status %0d, expected %0d", numbers_seen,
                             out_word.parse_status, want.status));
          if (out_word.end_position !== want.end_pos)
            report($sformatf("word %0d end position %0d, expected %0d", numbers_seen,
                             out_word.end_position, want.end_pos));
          if (out_word.minus_seen !== want.minus)
            report($sformatf("word %0d minus %b, expected %b", numbers_seen,
                             out_word.minus_seen, want.minus));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_word.valid = 1'b0;
    in_word.char_code = '0;
    in_word.last_char = 1'b0;
    error_count = 0;
    chars_sent = 0;
    numbers_seen = 0;
    strings_sent = 0;
    hold_req = 0;
    gaps_on = 1'b1;
    base_reg = strp_pkg::BASE_RESET;
    clear_string();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_limits();
    test_random_strings();
    test_backpressure();
    test_long_string();
    test_streaming();

    drain();
    repeat (8) @(negedge clk);
    if (pending_numbers.size() != 0)
      report($sformatf("%0d number words never arrived", pending_numbers.size()));

    $display("%0d characters in %0d strings, %0d number words checked", chars_sent,
             strings_sent, numbers_seen);
    $display("bases 0 to 63 incl. invalid, overflow, sign, hex prefix, stalls, long string");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
